/* rtl/telnet_option_filter_macros.svh */
// assertion macros shared by the telnet option filter modules
`ifndef TELNET_OPTION_FILTER_MACROS_SVH
`define TELNET_OPTION_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked property, idle while reset is asserted
`define TOF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// checked property, also evaluated during reset
`define TOF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define TOF_ASSERT(label, clk, rst_n, prop)
`define TOF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/tof_pkg.sv */
// types and constants of the telnet option filter
package tof_pkg;

  // telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // option codes
  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;

  // line end characters
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_NUL = 8'h00;

  // input kinds
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_SESSION = 1'b1;

  // parser modes
  typedef enum logic [2:0] {
    MODE_DATA   = 3'd0,
    MODE_IAC    = 3'd1,
    MODE_OPT    = 3'd2,
    MODE_SB     = 3'd3,
    MODE_SB_IAC = 3'd4
  } mode_t;

  // option verbs, in command byte order from WILL
  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_t;

  // reply byte position in the back end
  typedef enum logic [1:0] {
    BEAT_IDLE = 2'd0,
    BEAT_VERB = 2'd1,
    BEAT_OPT  = 2'd2
  } beat_t;

  // work passed from front to back: one data byte or one 3-byte reply
  typedef struct packed {
    logic       is_reply;
    logic [7:0] verb;
    logic [7:0] val;
  } cmd_t;

  // queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

/* rtl/tof_front.sv */
// front end: accepts bytes, runs the telnet parser and queues work
`include "telnet_option_filter_macros.svh"

module tof_front
  import tof_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_byte,
  input  q_status_t  q_status,
  output logic       push,
  output cmd_t       push_cmd
);

  mode_t mode_r, mode_nxt;
  verb_t verb_r, verb_nxt;
  logic  cr_seen_r, cr_seen_nxt;
  logic  echo_r, echo_nxt;
  logic  sga_r, sga_nxt;
  logic  acc;
  logic  is_verb;

  assign in_ready = !q_status.full;
  assign acc      = in_valid && in_ready;
  assign is_verb  = (in_byte >= B_WILL) && (in_byte <= B_DONT);

  // parser state, next value
  always_comb begin
    mode_nxt    = mode_r;
    verb_nxt    = verb_r;
    cr_seen_nxt = cr_seen_r;
    echo_nxt    = echo_r;
    sga_nxt     = sga_r;
    if (acc) begin
      if (in_action == ACT_SESSION) begin
        mode_nxt    = MODE_DATA;
        verb_nxt    = VERB_WILL;
        cr_seen_nxt = 1'b0;
        echo_nxt    = 1'b0;
        sga_nxt     = 1'b0;
      end else begin
        unique case (mode_r)
          MODE_IAC: begin
            if (in_byte == B_IAC) begin
              mode_nxt    = MODE_DATA;
              cr_seen_nxt = 1'b0;
            end else if (is_verb) begin
              verb_nxt = verb_t'(2'(in_byte - B_WILL));
              mode_nxt = MODE_OPT;
            end else if (in_byte == B_SB) begin
              mode_nxt = MODE_SB;
            end else begin
              mode_nxt = MODE_DATA;
            end
          end
          MODE_OPT: begin
            mode_nxt = MODE_DATA;
            if (verb_r == VERB_DO) begin
              if (in_byte == OPT_ECHO) begin
                echo_nxt = 1'b1;
              end else if (in_byte == OPT_SGA) begin
                sga_nxt = 1'b1;
              end
            end
          end
          MODE_SB: begin
            if (in_byte == B_IAC) begin
              mode_nxt = MODE_SB_IAC;
            end
          end
          MODE_SB_IAC: begin
            mode_nxt = (in_byte == B_SE) ? MODE_DATA : MODE_SB;
          end
          default: begin
            if (in_byte == B_IAC) begin
              mode_nxt = MODE_IAC;
            end else if (cr_seen_r && (in_byte == CH_NUL || in_byte == CH_LF)) begin
              mode_nxt    = MODE_DATA;
              cr_seen_nxt = 1'b0;
            end else begin
              mode_nxt    = MODE_DATA;
              cr_seen_nxt = (in_byte == CH_CR);
            end
          end
        endcase
      end
    end
  end

  // work item to the queue
  always_comb begin
    push              = 1'b0;
    push_cmd.is_reply = 1'b0;
    push_cmd.verb     = B_WILL;
    push_cmd.val      = in_byte;
    if (acc && in_action == ACT_BYTE) begin
      unique case (mode_r)
        MODE_IAC: begin
          if (in_byte == B_IAC) begin
            push = 1'b1;
          end
        end
        MODE_OPT: begin
          priority if (verb_r == VERB_DO) begin
            push_cmd.is_reply = 1'b1;
            if (in_byte == OPT_ECHO) begin
              push = !echo_r;
            end else if (in_byte == OPT_SGA) begin
              push = !sga_r;
            end else begin
              push          = 1'b1;
              push_cmd.verb = B_WONT;
            end
          end else if (verb_r == VERB_WILL) begin
            push              = 1'b1;
            push_cmd.is_reply = 1'b1;
            push_cmd.verb     = (in_byte == OPT_SGA) ? B_DO : B_DONT;
          end else begin
            push = 1'b0;
          end
        end
        MODE_SB, MODE_SB_IAC: begin
          push = 1'b0;
        end
        default: begin
          push = (in_byte != B_IAC) &&
                 !(cr_seen_r && (in_byte == CH_NUL || in_byte == CH_LF));
        end
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DATA;
      verb_r    <= VERB_WILL;
      cr_seen_r <= 1'b0;
      echo_r    <= 1'b0;
      sga_r     <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      verb_r    <= verb_nxt;
      cr_seen_r <= cr_seen_nxt;
      echo_r    <= echo_nxt;
      sga_r     <= sga_nxt;
    end
  end

  // a session start leaves the parser clean
  `TOF_ASSERT(a_session_clears, clk, rst_n,
    (acc && in_action == ACT_SESSION) |=> (mode_r == MODE_DATA && !echo_r && !sga_r))

endmodule

/* rtl/tof_queue.sv */
// short work queue between parser and output sequencer
`include "telnet_option_filter_macros.svh"

module tof_queue
  import tof_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      pop_cmd,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == FULL_CNT);
  assign pop_cmd      = entries_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  // fill count stays within the depth and tracks a lone pop
  `TOF_ASSERT(a_count_bound, clk, rst_n, count_r <= FULL_CNT)
  `TOF_ASSERT(a_pop_drains, clk, rst_n,
    (pop && !push) |=> (count_r == CNT_W'($past(count_r) - 1'b1)))

endmodule

/* rtl/tof_back.sv */
// back end: expands queued work into output items
`include "telnet_option_filter_macros.svh"

module tof_back
  import tof_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_status_t  q_status,
  input  cmd_t       pop_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_to_guest,
  output logic       out_last
);

  beat_t      beat_r, beat_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       guest_r, guest_nxt;
  logic       last_r, last_nxt;
  logic [7:0] verb_r, verb_nxt;
  logic [7:0] opt_r, opt_nxt;
  logic       load;

  assign load = !valid_r || out_ready;
  assign pop  = load && (beat_r == BEAT_IDLE) && !q_status.empty;

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_to_guest = guest_r;
  assign out_last     = last_r;

  // next output item
  always_comb begin
    beat_nxt  = beat_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    guest_nxt = guest_r;
    last_nxt  = last_r;
    verb_nxt  = verb_r;
    opt_nxt   = opt_r;
    if (load) begin
      unique case (beat_r)
        BEAT_VERB: begin
          valid_nxt = 1'b1;
          byte_nxt  = verb_r;
          guest_nxt = 1'b0;
          last_nxt  = 1'b0;
          beat_nxt  = BEAT_OPT;
        end
        BEAT_OPT: begin
          valid_nxt = 1'b1;
          byte_nxt  = opt_r;
          guest_nxt = 1'b0;
          last_nxt  = 1'b1;
          beat_nxt  = BEAT_IDLE;
        end
        default: begin
          valid_nxt = pop;
          if (pop) begin
            if (pop_cmd.is_reply) begin
              byte_nxt  = B_IAC;
              guest_nxt = 1'b0;
              last_nxt  = 1'b0;
              verb_nxt  = pop_cmd.verb;
              opt_nxt   = pop_cmd.val;
              beat_nxt  = BEAT_VERB;
            end else begin
              byte_nxt  = pop_cmd.val;
              guest_nxt = 1'b1;
              last_nxt  = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= BEAT_IDLE;
      valid_r <= 1'b0;
    end else begin
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    guest_r <= guest_nxt;
    last_r  <= last_nxt;
    verb_r  <= verb_nxt;
    opt_r   <= opt_nxt;
  end

  // a reply in flight always has its current byte on the output
  `TOF_ASSERT(a_reply_shown, clk, rst_n, (beat_r != BEAT_IDLE) |-> valid_r)
  // the third reply byte closes the item's results
  `TOF_ASSERT(a_reply_ends, clk, rst_n,
    (load && beat_r == BEAT_OPT) |=> (valid_r && last_r && !guest_r))

endmodule

/* rtl/telnet_option_filter.sv */
// telnet option filter: IAC parser, option answerer and guest data path
// path: an accepted byte is written into the work queue, then loaded into the output registers
// throughput: one input byte per cycle while the work queue is not full; a reply takes three output items,
//   and the work queue of QUEUE_DEPTH entries absorbs input meanwhile
// reset: synchronous active-low rst_n; parser returns to data mode, flags clear
module telnet_option_filter
  import tof_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] action
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] to_guest
  output logic       out_tlast
);

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      pop_cmd;

  // parser
  tof_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_action(in_tuser),
    .in_byte  (in_tdata),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // work queue
  tof_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .status  (q_status)
  );

  // output sequencer
  tof_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_status    (q_status),
    .pop_cmd     (pop_cmd),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .out_to_guest(out_tuser),
    .out_last    (out_tlast)
  );

endmodule

/* sim/telnet_option_filter_tb.sv */
// testbench for the telnet option filter: stream stimulus, predictor and result checks
`timescale 1ns / 100ps

module telnet_option_filter_tb;
  import tof_pkg::*;

  localparam int          RANDOM_ITEMS = 240;
  localparam int          MAX_GAP      = 14;
  localparam int          LONG_HOLD    = 120;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          REPORT_LIMIT = 10;
  localparam logic [7:0]  CMD_NOP      = 8'd241;

  // one received byte or a session start
  typedef struct {
    logic       act;
    logic [7:0] rx;
  } rx_item_t;

  // one output item as the filter should emit it
  typedef struct packed {
    logic [7:0] value;
    logic       to_guest;
    logic       is_last;
  } out_beat_t;

  // predicts guest data and negotiation replies, checks the output stream
  class telnet_stream_tracker;
    mode_t       mode;
    verb_t       verb;
    bit          cr_seen;
    bit          echo_done;
    bit          sga_done;
    out_beat_t   expected_beats[$];
    int          mismatches;
    int          checked;

    function new();
      clear_session();
      mismatches = 0;
      checked    = 0;
    endfunction

    function void clear_session();
      mode      = MODE_DATA;
      verb      = VERB_WILL;
      cr_seen   = 1'b0;
      echo_done = 1'b0;
      sga_done  = 1'b0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void push_data(logic [7:0] b);
      expected_beats.push_back('{value: b, to_guest: 1'b1, is_last: 1'b1});
    endfunction

    function void push_reply(logic [7:0] cmd, logic [7:0] opt);
      expected_beats.push_back('{value: B_IAC, to_guest: 1'b0, is_last: 1'b0});
      expected_beats.push_back('{value: cmd, to_guest: 1'b0, is_last: 1'b0});
      expected_beats.push_back('{value: opt, to_guest: 1'b0, is_last: 1'b1});
    endfunction

    // advance the parser by one accepted input item
    function void absorb_byte(logic act, logic [7:0] b);
      logic [7:0] offset;
      offset = b - B_WILL;
      if (act == ACT_SESSION) begin
        clear_session();
        return;
      end
      case (mode)
        MODE_IAC: begin
          if (b == B_IAC) begin
            mode    = MODE_DATA;
            cr_seen = 1'b0;
            push_data(B_IAC);
          end else if (b >= B_WILL && b <= B_DONT) begin
            verb = verb_t'(offset[1:0]);
            mode = MODE_OPT;
          end else begin
            mode = (b == B_SB) ? MODE_SB : MODE_DATA;
          end
        end
        MODE_OPT: begin
          mode = MODE_DATA;
          case (verb)
            VERB_DO: begin
              if (b == OPT_ECHO) begin
                if (!echo_done) begin
                  echo_done = 1'b1;
                  push_reply(B_WILL, b);
                end
              end else if (b == OPT_SGA) begin
                if (!sga_done) begin
                  sga_done = 1'b1;
                  push_reply(B_WILL, b);
                end
              end else begin
                push_reply(B_WONT, b);
              end
            end
            VERB_WILL: push_reply((b == OPT_SGA) ? B_DO : B_DONT, b);
            default: ;
          endcase
        end
        MODE_SB: begin
          if (b == B_IAC) mode = MODE_SB_IAC;
        end
        MODE_SB_IAC: begin
          mode = (b == B_SE) ? MODE_DATA : MODE_SB;
        end
        default: begin
          mode = MODE_DATA;
          if (b == B_IAC) begin
            mode = MODE_IAC;
          end else if (cr_seen && (b == CH_NUL || b == CH_LF)) begin
            cr_seen = 1'b0;
          end else begin
            cr_seen = (b == CH_CR);
            push_data(b);
          end
        end
      endcase
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endfunction

    // compare one accepted output item with the oldest prediction
    function void compare_output(logic [7:0] value, logic to_guest, logic is_last);
      out_beat_t want;
      checked++;
      if (expected_beats.size() == 0) begin
        note_failure($sformatf("output item %0d unexpected: byte %02h guest %0b last %0b",
                               checked, value, to_guest, is_last));
        return;
      end
      want = expected_beats.pop_front();
      if (want.value !== value || want.to_guest !== to_guest || want.is_last !== is_last)
        note_failure($sformatf(
          "output item %0d: expected byte %02h guest %0b last %0b, got %02h guest %0b last %0b",
          checked, want.value, want.to_guest, want.is_last, value, to_guest, is_last));
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  telnet_stream_tracker tracker = new();
  rx_item_t             rx_plan[$];
  int                   tight_left;
  int                   cycle_count;
  bit                   hold_output_request;

  telnet_option_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("telnet_option_filter: mismatch");
      $finish;
    end
  end

  function void plan_byte(logic [7:0] b);
    rx_plan.push_back('{act: ACT_BYTE, rx: b});
  endfunction

  function void plan_session(logic [7:0] b);
    rx_plan.push_back('{act: ACT_SESSION, rx: b});
  endfunction

  function void plan_option(logic [7:0] cmd, logic [7:0] opt);
    plan_byte(B_IAC);
    plan_byte(cmd);
    plan_byte(opt);
  endfunction

  // mostly well-formed telnet traffic with random content, some noise
  function void plan_sequence();
    int         pick;
    int         body;
    logic [7:0] opt;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      plan_byte(8'($urandom_range(0, 254)));
    end else if (pick < 42) begin
      plan_byte(CH_CR);
      case ($urandom_range(0, 3))
        0: plan_byte(CH_LF);
        1: plan_byte(CH_NUL);
        2: plan_byte(CH_CR);
        default: plan_byte(8'($urandom_range(0, 254)));
      endcase
    end else if (pick < 47) begin
      plan_byte(B_IAC);
      plan_byte(B_IAC);
    end else if (pick < 72) begin
      case ($urandom_range(0, 3))
        0: opt = OPT_ECHO;
        1: opt = OPT_SGA;
        default: opt = 8'($urandom_range(0, 255));
      endcase
      plan_option(8'(B_WILL + $urandom_range(0, 3)), opt);
    end else if (pick < 77) begin
      plan_byte(B_IAC);
      plan_byte(8'($urandom_range(0, 249)));
    end else if (pick < 85) begin
      plan_byte(B_IAC);
      plan_byte(B_SB);
      body = $urandom_range(0, 4);
      repeat (body) begin
        if ($urandom_range(0, 4) == 0) begin
          plan_byte(B_IAC);
          plan_byte(8'($urandom_range(0, 239)));
        end else begin
          plan_byte(8'($urandom_range(0, 254)));
        end
      end
      plan_byte(B_IAC);
      plan_byte(B_SE);
    end else if (pick < 88) begin
      plan_session(8'($urandom_range(0, 255)));
    end else begin
      rx_plan.push_back('{act: ($urandom_range(0, 7) == 0), rx: 8'($urandom_range(0, 255))});
    end
  endfunction

  // offer one item after a random gap and wait for its acceptance
  task automatic send_item(input rx_item_t one, input bit drain_first);
    int gap;
    if (tight_left > 0) begin
      gap = 0;
      tight_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 19) == 0) tight_left = $urandom_range(8, 30);
    end
    if (drain_first && gap == 0) gap = 1;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain_first && tracker.pending() != 0) @(posedge clk);
    end
    in_tdata  <= one.rx;
    in_tuser  <= one.act;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    tracker.absorb_byte(one.act, one.rx);
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int stall;
    int quiet_left;
    quiet_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_output_request) begin
        stall = LONG_HOLD;
        hold_output_request = 1'b0;
      end else if (quiet_left > 0) begin
        stall = 0;
        quiet_left--;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.compare_output(out_tdata, out_tuser, out_tlast);
    end
  end

  // reset, directed traffic, random traffic, drain and verdict
  initial begin : stimulus
    int sent;
    tight_left          = 0;
    hold_output_request = 1'b0;
    sent                = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, line ends, every verb, repeats, subnegotiation
    plan_session(8'hff);
    plan_byte(8'h00);
    plan_byte(8'hfe);
    plan_byte(B_IAC);
    plan_byte(B_IAC);
    plan_byte(CH_CR);
    plan_byte(CH_LF);
    plan_byte(CH_CR);
    plan_byte(CH_NUL);
    plan_option(B_DO, OPT_ECHO);
    plan_option(B_DO, OPT_ECHO);
    plan_option(B_DO, OPT_SGA);
    plan_option(B_DO, 8'h18);
    plan_option(B_WILL, OPT_SGA);
    plan_option(B_WILL, 8'h00);
    plan_option(B_WONT, OPT_ECHO);
    plan_option(B_DONT, 8'hff);
    plan_byte(B_IAC);
    plan_byte(CMD_NOP);
    plan_byte(B_IAC);
    plan_byte(B_SB);
    plan_byte(8'h18);
    plan_byte(B_IAC);
    plan_byte(8'h01);
    plan_byte(B_IAC);
    plan_byte(B_SE);
    while (rx_plan.size() != 0) send_item(rx_plan.pop_front(), 1'b0);

    // random traffic with one output hold-off and one full drain
    while (sent < RANDOM_ITEMS) begin
      plan_sequence();
      while (rx_plan.size() != 0) begin
        sent++;
        if (sent == 90) begin
          hold_output_request = 1'b1;
          tight_left          = 60;
        end
        send_item(rx_plan.pop_front(), sent == 190);
      end
    end
    in_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("telnet_option_filter: match");
    else
      $display("telnet_option_filter: mismatch");
    $finish;
  end

endmodule
